[rtl/baro_inertial_height_filter_assert.svh]
// Assertion macros for the baro-inertial height filter.
`ifndef BARO_INERTIAL_HEIGHT_FILTER_ASSERT_SVH
`define BARO_INERTIAL_HEIGHT_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define BIHF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define BIHF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BIHF_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define BIHF_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/bihf_pkg.sv]
// Types, constants, microcode and saturation helpers of the height filter.
`timescale 1ns / 1ps
`default_nettype none
package bihf_pkg;

   localparam int OMEGA_W  = 20;
   localparam int ST_W     = 48;
   localparam int ACC_W    = 50;
   localparam int MAG_W    = 44;
   localparam int DT_W     = 20;
   localparam int PROD_W   = 62;
   localparam int MUL_A_W  = 33;
   localparam int MUL_B_W  = 29;
   localparam int DVD_W    = 64;
   localparam int QUOT_W   = 44;
   localparam int REM_W    = 21;
   localparam int DIV_BITS = 4;
   localparam int DIV_STEPS = QUOT_W / DIV_BITS;
   localparam int CNT_W    = 4;
   localparam int PC_W     = 5;

   localparam logic [OMEGA_W-1:0]      OMEGA_RESET = 20'd196608;
   localparam logic signed [ACC_W-1:0] GRAVITY_Q   = 50'sd642689;
   localparam logic [31:0]             TIMEOUT_US  = 32'd1000000;
   localparam logic [DT_W-1:0]         RESTART_DT  = 20'd20000;
   localparam logic [REM_W-1:0]        US_PER_S    = 21'd1000000;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } seq_state_type;

   typedef enum logic [3:0] {
      ALU_NOP, ALU_PREP, ALU_W2, ALU_W3, ALU_ERR, ALU_IN1, ALU_IN2, ALU_IN3,
      ALU_MAG, ALU_PHI, ALU_PSUM, ALU_APPLY
   } alu_op_type;

   typedef enum logic [2:0] {
      MUL_NONE, MUL_WW, MUL_W2W, MUL_EW3, MUL_EW2, MUL_EW, MUL_HI, MUL_LO
   } mul_sel_type;

   typedef enum logic [1:0] {
      DST_BIAS, DST_RATE, DST_HEIGHT
   } dst_sel_type;

   typedef enum logic [1:0] {
      SEQ_NEXT, SEQ_WAIT_DIV, SEQ_DONE
   } seq_op_type;

   typedef struct packed {
      alu_op_type  alu;
      mul_sel_type mul;
      dst_sel_type dst;
      seq_op_type  seq;
   } ctrl_word_type;

   typedef struct packed {
      logic div_busy;
      logic out_free;
   } status_type;

   localparam ctrl_word_type CTRL_IDLE = '{ALU_NOP, MUL_NONE, DST_BIAS, SEQ_NEXT};

   // microprogram: one word per step
   function automatic ctrl_word_type ucode(input logic [PC_W-1:0] pc);
      case (pc)
         5'd0:  return '{ALU_PREP,  MUL_WW,   DST_BIAS,   SEQ_NEXT};
         5'd1:  return '{ALU_W2,    MUL_NONE, DST_BIAS,   SEQ_NEXT};
         5'd2:  return '{ALU_ERR,   MUL_W2W,  DST_BIAS,   SEQ_NEXT};
         5'd3:  return '{ALU_W3,    MUL_NONE, DST_BIAS,   SEQ_NEXT};
         5'd4:  return '{ALU_NOP,   MUL_EW3,  DST_BIAS,   SEQ_NEXT};
         5'd5:  return '{ALU_IN1,   MUL_NONE, DST_BIAS,   SEQ_NEXT};
         5'd6:  return '{ALU_MAG,   MUL_NONE, DST_BIAS,   SEQ_NEXT};
         5'd7:  return '{ALU_NOP,   MUL_HI,   DST_BIAS,   SEQ_NEXT};
         5'd8:  return '{ALU_PHI,   MUL_LO,   DST_BIAS,   SEQ_NEXT};
         5'd9:  return '{ALU_PSUM,  MUL_NONE, DST_BIAS,   SEQ_NEXT};
         5'd10: return '{ALU_NOP,   MUL_NONE, DST_BIAS,   SEQ_WAIT_DIV};
         5'd11: return '{ALU_APPLY, MUL_EW2,  DST_BIAS,   SEQ_NEXT};
         5'd12: return '{ALU_IN2,   MUL_NONE, DST_BIAS,   SEQ_NEXT};
         5'd13: return '{ALU_MAG,   MUL_NONE, DST_RATE,   SEQ_NEXT};
         5'd14: return '{ALU_NOP,   MUL_HI,   DST_RATE,   SEQ_NEXT};
         5'd15: return '{ALU_PHI,   MUL_LO,   DST_RATE,   SEQ_NEXT};
         5'd16: return '{ALU_PSUM,  MUL_NONE, DST_RATE,   SEQ_NEXT};
         5'd17: return '{ALU_NOP,   MUL_NONE, DST_RATE,   SEQ_WAIT_DIV};
         5'd18: return '{ALU_APPLY, MUL_EW,   DST_RATE,   SEQ_NEXT};
         5'd19: return '{ALU_IN3,   MUL_NONE, DST_HEIGHT, SEQ_NEXT};
         5'd20: return '{ALU_MAG,   MUL_NONE, DST_HEIGHT, SEQ_NEXT};
         5'd21: return '{ALU_NOP,   MUL_HI,   DST_HEIGHT, SEQ_NEXT};
         5'd22: return '{ALU_PHI,   MUL_LO,   DST_HEIGHT, SEQ_NEXT};
         5'd23: return '{ALU_PSUM,  MUL_NONE, DST_HEIGHT, SEQ_NEXT};
         5'd24: return '{ALU_NOP,   MUL_NONE, DST_HEIGHT, SEQ_WAIT_DIV};
         5'd25: return '{ALU_APPLY, MUL_NONE, DST_HEIGHT, SEQ_NEXT};
         5'd26: return '{ALU_NOP,   MUL_NONE, DST_HEIGHT, SEQ_DONE};
         default: return '{ALU_NOP, MUL_NONE, DST_BIAS,   SEQ_DONE};
      endcase
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      if (v[ACC_W-1:31] == {(ACC_W-31){v[ACC_W-1]}}) return v[31:0];
      return v[ACC_W-1] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
   endfunction

   function automatic logic signed [MAG_W-1:0] sat44(input logic signed [ACC_W-1:0] v);
      if (v[ACC_W-1:MAG_W-1] == {(ACC_W-MAG_W+1){v[ACC_W-1]}}) return v[MAG_W-1:0];
      return v[ACC_W-1] ? {1'b1, {(MAG_W-1){1'b0}}} : {1'b0, {(MAG_W-1){1'b1}}};
   endfunction

   function automatic logic signed [ST_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
      if (v[ACC_W-1:ST_W-1] == {(ACC_W-ST_W+1){v[ACC_W-1]}}) return v[ST_W-1:0];
      return v[ACC_W-1] ? {1'b1, {(ST_W-1){1'b0}}} : {1'b0, {(ST_W-1){1'b1}}};
   endfunction

endpackage
`default_nettype wire

[rtl/bihf_div.sv]
// Radix-16 restoring divider of a step product by one million.
`timescale 1ns / 1ps
`default_nettype none
module bihf_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bihf_pkg::DVD_W-1:0]    dividend,
   output logic                          busy,
   output logic [bihf_pkg::QUOT_W-1:0]   quot,
   output logic                          rem_nz
);
   import bihf_pkg::*;

   logic [REM_W-1:0]  rem_ff, rem_in, step_rem;
   logic [QUOT_W-1:0] num_ff, num_in, step_num;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;

   // four quotient bits per cycle; quotient fills num from the bottom
   always_comb begin
      step_rem = rem_ff;
      step_num = num_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         step_rem = {step_rem[REM_W-2:0], step_num[QUOT_W-1]};
         step_num = {step_num[QUOT_W-2:0], 1'b0};
         if (step_rem >= US_PER_S) begin
            step_rem   = step_rem - US_PER_S;
            step_num[0] = 1'b1;
         end
      end
   end

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         // top bits of the dividend are already below the divisor
         rem_in  = {1'b0, dividend[DVD_W-1:QUOT_W]};
         num_in  = dividend[QUOT_W-1:0];
         cnt_in  = CNT_W'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = step_rem;
         num_in  = step_num;
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
   end

   assign busy   = busy_ff;
   assign quot   = num_ff;
   assign rem_nz = (rem_ff != '0);

endmodule
`default_nettype wire

[rtl/bihf_datapath.sv]
// Filter datapath: state, shared multiplier, adder/saturation, output register.
`timescale 1ns / 1ps
`default_nettype none
module bihf_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [19:0]             csr_wr_data,
   input  logic                    accept,
   input  logic [31:0]             in_time_us,
   input  logic signed [31:0]      in_height_meas,
   input  logic signed [24:0]      in_vert_accel,
   input  bihf_pkg::ctrl_word_type ctrl,
   output bihf_pkg::status_type    status,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic signed [31:0]      rsp_height_rate_est,
   output logic signed [31:0]      rsp_height_est,
   output logic                    rsp_restarted
);
   import bihf_pkg::*;

   logic [OMEGA_W-1:0]      omega_ff, omega_in;
   logic [31:0]             last_time_ff, last_time_in;
   logic signed [ST_W-1:0]  bias_ff, bias_in, rate_ff, rate_in, height_ff, height_in;
   logic [31:0]             time_ff, time_in;
   logic signed [31:0]      hm_ff, hm_in;
   logic signed [24:0]      va_ff, va_in;
   logic [DT_W-1:0]         dt_ff, dt_in;
   logic                    restart_ff, restart_in;
   logic [23:0]             w2_ff, w2_in;
   logic [27:0]             w3_ff, w3_in;
   logic signed [31:0]      err_ff, err_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic [41:0]             phi_ff, phi_in;
   logic                    out_valid_ff, out_valid_in;
   logic signed [31:0]      out_rate_ff, out_rate_in, out_height_ff, out_height_in;
   logic                    out_restart_ff, out_restart_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_out;
   logic [31:0]               diff;
   logic [DVD_W-1:0]          dividend;
   logic                      div_start, div_busy, rem_nz;
   logic [QUOT_W-1:0]         quot;
   logic signed [ST_W-1:0]    apply_state, applied;
   logic signed [ACC_W-1:0]   qmag, qval, t2x, t3x, err_wide;
   logic signed [MAG_W-1:0]   in_sat;
   logic signed [MAG_W:0]     in_abs;
   logic                      out_free, out_load;

   // shared multiplier operand select
   always_comb begin
      case (ctrl.mul)
         MUL_WW: begin
            mul_a = {13'd0, omega_ff};
            mul_b = {9'd0, omega_ff};
         end
         MUL_W2W: begin
            mul_a = {9'd0, w2_ff};
            mul_b = {9'd0, omega_ff};
         end
         MUL_EW3: begin
            mul_a = {err_ff[31], err_ff};
            mul_b = {1'b0, w3_ff};
         end
         MUL_EW2: begin
            mul_a = {err_ff[31], err_ff};
            mul_b = {5'd0, w2_ff};
         end
         MUL_EW: begin
            mul_a = {err_ff[31], err_ff};
            mul_b = {9'd0, omega_ff};
         end
         MUL_HI: begin
            mul_a = {11'd0, mag_ff[43:22]};
            mul_b = {9'd0, dt_ff};
         end
         MUL_LO: begin
            mul_a = {11'd0, mag_ff[21:0]};
            mul_b = {9'd0, dt_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_out  = mul_a * mul_b;
   assign diff     = time_ff - last_time_ff;
   assign dividend = {phi_ff, 22'd0} + {22'd0, prod_ff[41:0]};

   // integrator step: floor(in * dt / 1e6) rebuilt from magnitude quotient;
   // a negative step rounds its magnitude up
   always_comb begin
      case (ctrl.dst)
         DST_BIAS:   apply_state = bias_ff;
         DST_RATE:   apply_state = rate_ff;
         DST_HEIGHT: apply_state = height_ff;
         default:    apply_state = bias_ff;
      endcase
      qmag    = {{(ACC_W-QUOT_W){1'b0}}, quot} + {{(ACC_W-1){1'b0}}, neg_ff & rem_nz};
      qval    = neg_ff ? -qmag : qmag;
      applied = sat48({{(ACC_W-ST_W){apply_state[ST_W-1]}}, apply_state} + qval);
   end

   // 3 * (err * w^k >> 16)
   assign t2x = {{10{prod_ff[55]}}, prod_ff[55:16]} + {{9{prod_ff[55]}}, prod_ff[55:16], 1'b0};
   assign t3x = {{14{prod_ff[51]}}, prod_ff[51:16]} + {{13{prod_ff[51]}}, prod_ff[51:16], 1'b0};
   assign err_wide = {{(ACC_W-32){hm_ff[31]}}, hm_ff}
                   - {{(ACC_W-ST_W){height_ff[ST_W-1]}}, height_ff};
   assign in_sat = sat44(acc_ff);
   assign in_abs = in_sat[MAG_W-1] ? -{in_sat[MAG_W-1], in_sat} : {in_sat[MAG_W-1], in_sat};

   assign out_free = !out_valid_ff || rsp_tready;
   assign out_load = (ctrl.seq == SEQ_DONE) && out_free;

   always_comb begin
      omega_in     = omega_ff;
      last_time_in = last_time_ff;
      bias_in      = bias_ff;
      rate_in      = rate_ff;
      height_in    = height_ff;
      time_in      = time_ff;
      hm_in        = hm_ff;
      va_in        = va_ff;
      dt_in        = dt_ff;
      restart_in   = restart_ff;
      w2_in        = w2_ff;
      w3_in        = w3_ff;
      err_in       = err_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      phi_in       = phi_ff;
      div_start    = 1'b0;
      if (csr_wr_en) begin
         omega_in = csr_wr_data;
      end
      if (accept) begin
         time_in = in_time_us;
         hm_in   = in_height_meas;
         va_in   = in_vert_accel;
      end
      if (ctrl.mul != MUL_NONE) begin
         prod_in = mul_out;
      end
      case (ctrl.alu)
         ALU_PREP: begin
            last_time_in = time_ff;
            if (diff > TIMEOUT_US) begin
               height_in  = {{(ST_W-32){hm_ff[31]}}, hm_ff};
               rate_in    = '0;
               bias_in    = '0;
               dt_in      = RESTART_DT;
               restart_in = 1'b1;
            end else begin
               dt_in      = diff[DT_W-1:0];
               restart_in = 1'b0;
            end
         end
         ALU_W2:  w2_in  = prod_ff[39:16];
         ALU_W3:  w3_in  = prod_ff[43:16];
         ALU_ERR: err_in = sat32(err_wide);
         ALU_IN1: acc_in = {{(ACC_W-44){prod_ff[59]}}, prod_ff[59:16]};
         ALU_IN2: begin
            acc_in = {{(ACC_W-ST_W){bias_ff[ST_W-1]}}, bias_ff} + t2x
                   - {{(ACC_W-25){va_ff[24]}}, va_ff} - GRAVITY_Q;
         end
         ALU_IN3: acc_in = {{(ACC_W-ST_W){rate_ff[ST_W-1]}}, rate_ff} + t3x;
         ALU_MAG: begin
            neg_in = in_sat[MAG_W-1];
            mag_in = in_abs[MAG_W-1:0];
         end
         ALU_PHI:  phi_in    = prod_ff[41:0];
         ALU_PSUM: div_start = 1'b1;
         ALU_APPLY: begin
            case (ctrl.dst)
               DST_BIAS:   bias_in   = applied;
               DST_RATE:   rate_in   = applied;
               DST_HEIGHT: height_in = applied;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      out_valid_in   = out_load ? 1'b1 : (out_valid_ff && !rsp_tready);
      out_rate_in    = out_rate_ff;
      out_height_in  = out_height_ff;
      out_restart_in = out_restart_ff;
      if (out_load) begin
         out_rate_in    = sat32({{(ACC_W-ST_W){rate_ff[ST_W-1]}}, rate_ff});
         out_height_in  = sat32({{(ACC_W-ST_W){height_ff[ST_W-1]}}, height_ff});
         out_restart_in = restart_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         omega_ff     <= OMEGA_RESET;
         last_time_ff <= '0;
         bias_ff      <= '0;
         rate_ff      <= '0;
         height_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         omega_ff     <= omega_in;
         last_time_ff <= last_time_in;
         bias_ff      <= bias_in;
         rate_ff      <= rate_in;
         height_ff    <= height_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      time_ff        <= time_in;
      hm_ff          <= hm_in;
      va_ff          <= va_in;
      dt_ff          <= dt_in;
      restart_ff     <= restart_in;
      w2_ff          <= w2_in;
      w3_ff          <= w3_in;
      err_ff         <= err_in;
      prod_ff        <= prod_in;
      acc_ff         <= acc_in;
      mag_ff         <= mag_in;
      neg_ff         <= neg_in;
      phi_ff         <= phi_in;
      out_rate_ff    <= out_rate_in;
      out_height_ff  <= out_height_in;
      out_restart_ff <= out_restart_in;
   end

   bihf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .busy     (div_busy),
      .quot     (quot),
      .rem_nz   (rem_nz)
   );

   assign status.div_busy     = div_busy;
   assign status.out_free     = out_free;
   assign rsp_tvalid          = out_valid_ff;
   assign rsp_height_rate_est = out_rate_ff;
   assign rsp_height_est      = out_height_ff;
   assign rsp_restarted       = out_restart_ff;

endmodule
`default_nettype wire

[rtl/bihf_sequencer.sv]
// Microcode sequencer: step counter, control ROM and wait/done jumps.
`timescale 1ns / 1ps
`default_nettype none
module bihf_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  bihf_pkg::status_type    status,
   output bihf_pkg::ctrl_word_type ctrl,
   output logic                    ready
);
   import bihf_pkg::*;

   seq_state_type   state_ff, state_in;
   logic [PC_W-1:0] pc_ff, pc_in;

   assign ctrl  = (state_ff == ST_RUN) ? ucode(pc_ff) : CTRL_IDLE;
   assign ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               pc_in    = '0;
            end
         end
         ST_RUN: begin
            case (ctrl.seq)
               SEQ_NEXT: pc_in = pc_ff + PC_W'(1);
               SEQ_WAIT_DIV: begin
                  if (!status.div_busy) pc_in = pc_ff + PC_W'(1);
               end
               SEQ_DONE: begin
                  // hold until the output register can take the beat
                  if (status.out_free) state_in = ST_IDLE;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

endmodule
`default_nettype wire

[rtl/baro_inertial_height_filter.sv]
// Top level of the third-order baro-inertial height filter.
//
//   channel  | dir | handshake            | payload
//   req      | in  | req_tvalid/tready    | tdata: time_us, height_meas, vert_accel
//   rsp      | out | rsp_tvalid/tready    | tdata: height_rate_est, height_est; tuser
//   csr      | in  | csr_wr_en            | csr_wr_data: omega
//
// Each accepted sample runs a 27-step microprogram on one shared 33x29 multiplier, and
// each of its three wait steps is held by a radix-16 division by one million. A new
// sample is taken once the sequencer is back in idle, so a new sample is not taken
// before the last one's result is loaded; a held result only stalls the sequencer on
// its last step. Synchronous reset clears the integrators and the last timestamp and
// sets omega to 3.0.
`timescale 1ns / 1ps
`default_nettype none
`include "baro_inertial_height_filter_assert.svh"
module baro_inertial_height_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [19:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // time_us[31:0], height_meas[63:32], vert_accel[88:64]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // height_rate_est[31:0], height_est[63:32]
   output logic        rsp_tuser    // restarted
);
   import bihf_pkg::*;

   ctrl_word_type      ctrl;
   status_type         status;
   logic               accept;
   logic signed [31:0] rate_est, height_est;

   assign accept = req_tvalid && req_tready;

   bihf_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .status (status),
      .ctrl   (ctrl),
      .ready  (req_tready)
   );

   bihf_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .accept              (accept),
      .in_time_us          (req_tdata[31:0]),
      .in_height_meas      (req_tdata[63:32]),
      .in_vert_accel       (req_tdata[88:64]),
      .ctrl                (ctrl),
      .status              (status),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_height_rate_est (rate_est),
      .rsp_height_est      (height_est),
      .rsp_restarted       (rsp_tuser)
   );

   assign rsp_tdata = {height_est, rate_est};

   `BIHF_ASSERT_SAME(a_div_only_in_wait, clock, reset, status.div_busy, ctrl.seq == SEQ_WAIT_DIV, "divider busy outside a wait step")
   `BIHF_ASSERT_NEXT(a_one_sample_at_once, clock, reset, accept, !req_tready, "second sample taken while running")
   `BIHF_ASSERT_SAME(a_result_from_done, clock, reset, $rose(rsp_tvalid), $past(ctrl.seq == SEQ_DONE), "result shown without a done step")

endmodule
`default_nettype wire

[sim/tb_baro_inertial_height_filter.sv]
// Self-checking testbench of the baro-inertial height filter: stream stimulus and scoreboard.
`timescale 1ns / 1ps

module tb_baro_inertial_height_filter;

   localparam longint GRAVITY    = 642689;
   localparam longint US_PER_S   = 1000000;
   localparam longint STEP_LIMIT = 1000000;
   localparam longint RESTART_US = 20000;
   localparam longint ST_HI      = (longint'(1) << 47) - 1;
   localparam longint ST_LO      = -(longint'(1) << 47);
   localparam longint IN_HI      = (longint'(1) << 43) - 1;
   localparam longint IN_LO      = -(longint'(1) << 43);
   localparam longint S32_HI     = (longint'(1) << 31) - 1;
   localparam longint S32_LO     = -(longint'(1) << 31);
   localparam logic [19:0] OMEGA_DEFAULT = 20'd196608;
   localparam logic [19:0] OMEGA_MAX     = 20'hFFFFF;
   localparam int IDLE_LIMIT   = 5000;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_ITEMS  = 233;

   typedef struct {
      logic [31:0] rate;
      logic [31:0] height;
      logic        restarted;
   } height_estimate_type;

   class height_scoreboard;
      bit [31:0]           prev_stamp;
      longint              bias_acc, rate_acc, height_acc;
      bit [19:0]           omega_q;
      height_estimate_type pending_q[$];
      int                  errors, n_checked, n_restarts;

      function new();
         prev_stamp = '0;
         bias_acc   = 0;
         rate_acc   = 0;
         height_acc = 0;
         omega_q    = OMEGA_DEFAULT;
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      // Euler step, increment floored after scaling by dt in us
      function longint advance(longint state, longint inp, longint dt);
         longint p, q;
         p = clip(inp, IN_LO, IN_HI) * dt;
         if (p >= 0) q = p / US_PER_S;
         else q = -((-p + US_PER_S - 1) / US_PER_S);
         return clip(state + q, ST_LO, ST_HI);
      endfunction

      function void note_sample(bit [31:0] stamp, logic signed [31:0] hm,
                                logic signed [24:0] acc);
         bit [31:0]           diff;
         longint              dt, w, w2, w3, err, ddot, in1, in2, in3;
         height_estimate_type e;
         diff = stamp - prev_stamp;
         dt   = longint'(diff);
         e.restarted = 1'b0;
         if (longint'(diff) > STEP_LIMIT) begin
            height_acc  = longint'(hm);
            rate_acc    = 0;
            bias_acc    = 0;
            dt          = RESTART_US;
            e.restarted = 1'b1;
            n_restarts++;
         end
         prev_stamp = stamp;
         w    = longint'(omega_q);
         w2   = (w * w) >>> 16;
         w3   = (w2 * w) >>> 16;
         err  = clip(longint'(hm) - height_acc, S32_LO, S32_HI);
         ddot = -(longint'(acc) + GRAVITY);
         in1  = (err * w3) >>> 16;
         bias_acc = advance(bias_acc, in1, dt);
         in2  = bias_acc + ddot + 3 * ((err * w2) >>> 16);
         rate_acc = advance(rate_acc, in2, dt);
         in3  = rate_acc + 3 * ((err * w) >>> 16);
         height_acc = advance(height_acc, in3, dt);
         e.rate   = 32'(clip(rate_acc, S32_LO, S32_HI));
         e.height = 32'(clip(height_acc, S32_LO, S32_HI));
         pending_q.push_back(e);
      endfunction

      function void check_result(logic [31:0] rate, logic [31:0] height, logic restarted);
         height_estimate_type e;
         if (pending_q.size() == 0) begin
            if (errors < 10)
               $display("%0t: result beat with nothing expected: rate %h height %h",
                        $realtime, rate, height);
            errors++;
            return;
         end
         e = pending_q.pop_front();
         n_checked++;
         if (rate !== e.rate || height !== e.height || restarted !== e.restarted) begin
            if (errors < 10)
               $display("%0t: result %0d: rate exp %h got %h, height exp %h got %h, restart exp %0b got %0b",
                        $realtime, n_checked, e.rate, rate, e.height, height,
                        e.restarted, restarted);
            errors++;
         end
      endfunction

      function int pending();
         return pending_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [19:0] csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;

   height_scoreboard sb = new();

   int          n_accepted = 0;
   int          burst_left = 0;
   int          n_settings = 1;
   int          n_holds = 0;
   int          idle_cycles = 0;
   logic [31:0] t_now = '0;
   logic [31:0] h_now = '0;

   baro_inertial_height_filter uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_sample(input logic [31:0] stamp, input logic [31:0] hm,
                              input logic [24:0] acc);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat (($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6))
            @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, acc, hm, stamp};
      do @(posedge clock); while (!req_tready);
      sb.note_sample(stamp, hm, acc);
      n_accepted++;
      t_now = stamp;
      h_now = hm;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_random_samples(input int count);
      int unsigned sel;
      logic [31:0] stamp, hm;
      logic [24:0] acc;
      for (int i = 0; i < count; i++) begin
         // mostly a steady 50 Hz stream, with repeats, long gaps and stray stamps
         sel = $urandom_range(0, 99);
         if (sel < 70)      stamp = t_now + $urandom_range(15000, 25000);
         else if (sel < 78) stamp = t_now;
         else if (sel < 88) stamp = t_now + $urandom_range(25000, 1000000);
         else if (sel < 92) stamp = t_now + 32'(STEP_LIMIT) + $urandom_range(0, 1);
         else if (sel < 96) stamp = t_now + $urandom_range(1000001, 3000000);
         else               stamp = $urandom();
         sel = $urandom_range(0, 99);
         if (sel < 60) hm = h_now + 32'(int'($urandom_range(0, 524288)) - 262144);
         else if (sel < 80) hm = $urandom();
         else begin
            case ($urandom_range(0, 3))
               0: hm = 32'h7FFF_FFFF;
               1: hm = 32'h8000_0000;
               2: hm = 32'h0;
               default: hm = 32'hFFFF_FFFF;
            endcase
         end
         sel = $urandom_range(0, 99);
         if (sel < 60) acc = 25'(-GRAVITY + longint'($urandom_range(0, 131072)) - 65536);
         else if (sel < 80) acc = 25'($urandom());
         else begin
            case ($urandom_range(0, 3))
               0: acc = 25'h0FF_FFFF;
               1: acc = 25'h100_0000;
               2: acc = 25'h0;
               default: acc = 25'h1FF_FFFF;
            endcase
         end
         send_sample(stamp, hm, acc);
      end
   endtask

   // waits for the block to go idle, then rewrites omega
   task automatic write_omega(input logic [19:0] value);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      sb.omega_q = value;
      n_settings++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // result side: stall patterns in segments, plus long hold-offs
   initial begin
      int mode, seg_left, hold_idx;
      int hold_at[2];
      mode = 0;
      seg_left = 0;
      hold_idx = 0;
      hold_at[0] = 300;
      hold_at[1] = 1100;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_idx < 2 && n_accepted >= hold_at[hold_idx]) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_idx++;
            n_holds++;
         end else begin
            if (seg_left == 0) begin
               mode = $urandom_range(0, 3);
               seg_left = $urandom_range(20, 300);
            end
            seg_left--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (seg_left % 5 == 0);
               default: rsp_tready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                  IDLE_LIMIT, sb.pending());
         $display("** baro_inertial_height_filter: FAILED **");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: zero step, timeout boundary, field extremes, saturation, wrap
      send_sample(32'd0,          32'h0000_0000, 25'h0);
      send_sample(32'd20000,      32'h0001_0000, 25'(-GRAVITY));
      send_sample(32'd20000,      32'h0001_0000, 25'(-GRAVITY));
      send_sample(32'd1020000,    32'h0002_0000, 25'h0);
      send_sample(32'd2020001,    32'h0003_0000, 25'h0);
      send_sample(32'd2040001,    32'h7FFF_FFFF, 25'h0FF_FFFF);
      send_sample(32'd2060001,    32'h8000_0000, 25'h100_0000);
      send_sample(32'd3060001,    32'h7FFF_FFFF, 25'h0);
      send_sample(32'd4060001,    32'h8000_0000, 25'h100_0000);
      send_sample(32'd5060001,    32'h7FFF_FFFF, 25'h0FF_FFFF);
      send_sample(32'd6060001,    32'h7FFF_FFFF, 25'h100_0000);
      send_sample(32'd7060001,    32'h7FFF_FFFF, 25'h0FF_FFFF);
      send_sample(32'd8060001,    32'h8000_0000, 25'h0FF_FFFF);
      send_sample(32'hFFFF_FFFF,  32'hFFFF_0000, 25'h0);
      send_sample(32'h0000_4E1F,  32'hFFFF_0000, 25'h1FF_FFFF);
      send_sample(32'h0000_9C3F,  32'h7FFF_FFFF, 25'h0);
      send_sample(32'h8000_0000,  32'h0000_0000, 25'h0);
      send_sample(32'h8000_0001,  32'h0000_0064, 25'h1FF_FFFF);
      send_sample(32'h800F_4241,  32'h5555_AAAA, 25'h0AA_5555);
      send_random_samples(PHASE_ITEMS - 100);

      write_omega(20'd0);
      send_random_samples(PHASE_ITEMS);
      write_omega(OMEGA_MAX);
      send_random_samples(PHASE_ITEMS);
      write_omega(20'd65536);
      send_random_samples(PHASE_ITEMS);
      write_omega(20'($urandom_range(0, 20'hFFFFF)));
      send_random_samples(PHASE_ITEMS);
      write_omega(20'd1);
      send_random_samples(PHASE_ITEMS);
      write_omega(OMEGA_DEFAULT);
      send_random_samples(PHASE_ITEMS + 100);
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Run covered %0d samples, %0d checked, %0d timeout restarts, %0d omega settings.",
               n_accepted, sb.n_checked, sb.n_restarts, n_settings);
      $display("Output side held off %0d times for %0d cycles; %0d mismatches, %0d left over.",
               n_holds, HOLD_CYCLES, sb.errors, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0)
         $display("** baro_inertial_height_filter: PASSED **");
      else
         $display("** baro_inertial_height_filter: FAILED **");
      $finish;
   end

endmodule
